[design/icy_pkg.sv]
// shared types, codes and constants for the icy metadata demux
`timescale 1ns / 1ps

package icy_pkg;

    localparam logic [3:0] PREFIX_LEN  = 4'd13;
    localparam logic [7:0] CHAR_QUOTE  = 8'h27;
    localparam logic [7:0] CHAR_SEMI   = 8'h3B;
    localparam logic [7:0] CHAR_S      = 8'h53;
    localparam logic [7:0] CHAR_NUL    = 8'h00;

    localparam logic [1:0] KIND_AUDIO    = 2'd0;
    localparam logic [1:0] KIND_TITLE    = 2'd1;
    localparam logic [1:0] KIND_COMPLETE = 2'd2;
    localparam logic [1:0] KIND_DISCARD  = 2'd3;

    typedef enum logic [2:0] {
        PH_AUDIO  = 3'b001,
        PH_LENGTH = 3'b010,
        PH_META   = 3'b100
    } frame_phase_t;

    typedef enum logic [2:0] {
        SP_SEARCH = 3'b001,
        SP_TITLE  = 3'b010,
        SP_DONE   = 3'b100
    } search_phase_t;

    typedef struct packed {
        logic [1:0] kind;
        logic [7:0] data;
    } result_t;

    typedef struct packed {
        result_t [2:0] res;
        logic [1:0]    count;
    } bundle_t;

    // characters of StreamTitle='
    function automatic logic [7:0] prefix_char(input logic [3:0] idx);
        logic [7:0] c;
        begin
            case (idx)
                4'd0:    c = 8'h53;
                4'd1:    c = 8'h74;
                4'd2:    c = 8'h72;
                4'd3:    c = 8'h65;
                4'd4:    c = 8'h61;
                4'd5:    c = 8'h6D;
                4'd6:    c = 8'h54;
                4'd7:    c = 8'h69;
                4'd8:    c = 8'h74;
                4'd9:    c = 8'h6C;
                4'd10:   c = 8'h65;
                4'd11:   c = 8'h3D;
                4'd12:   c = 8'h27;
                default: c = 8'h00;
            endcase
            return c;
        end
    endfunction

endpackage

[design/icy_ifs.sv]
// stream and configuration channel interfaces
`timescale 1ns / 1ps

interface icy_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    modport source (output valid, output in_byte, input ready);
    modport sink (input valid, input in_byte, output ready);
endinterface

interface icy_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] out_kind;
    logic [7:0] out_byte;
    logic       last_of_run;
    modport source (output valid, output out_kind, output out_byte, output last_of_run,
                    input ready);
    modport sink (input valid, input out_kind, input out_byte, input last_of_run,
                  output ready);
endinterface

interface icy_cfg_if;
    logic        valid;
    logic        ready;
    logic [15:0] metadata_interval;
    modport source (output valid, output metadata_interval, input ready);
    modport sink (input valid, input metadata_interval, output ready);
endinterface

[design/icy_metadata_demux.sv]
// top level of the icy metadata demux
`timescale 1ns / 1ps

// Splits an ICY stream body into audio bytes and stream-title events. Each input
// transaction carries one stream byte and causes zero to three output transactions;
// last_of_run marks the final one of each byte. While the output side is ready a
// byte is taken every cycle as long as the byte before it caused at most one result;
// a byte that causes two or three results blocks the input while the single output
// register drains, and the next byte is taken in the cycle the last result leaves.
// The metadata_interval register is written through the cfg channel, which is always
// ready; the user must write it only while the block is idle, as the block itself does
// not enforce this. Zero passes every byte through as audio.
module icy_metadata_demux (
    input  logic        clk,
    input  logic        rst_n,
    icy_in_if.sink      in_stream,
    icy_out_if.source   out_stream,
    icy_cfg_if.sink     cfg
);

    logic             can_load;
    logic             load;
    icy_pkg::bundle_t bundle;

    icy_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_stream.valid),
        .in_byte   (in_stream.in_byte),
        .in_ready  (in_stream.ready),
        .cfg_valid (cfg.valid),
        .cfg_data  (cfg.metadata_interval),
        .cfg_ready (cfg.ready),
        .can_load  (can_load),
        .load      (load),
        .bundle    (bundle)
    );

    icy_out_buf u_out_buf (
        .clk         (clk),
        .rst_n       (rst_n),
        .load        (load),
        .bundle      (bundle),
        .can_load    (can_load),
        .out_valid   (out_stream.valid),
        .out_ready   (out_stream.ready),
        .out_kind    (out_stream.out_kind),
        .out_byte    (out_stream.out_byte),
        .last_of_run (out_stream.last_of_run)
    );

endmodule

[design/icy_parser.sv]
// framing and title scan state with per-byte result generation
`timescale 1ns / 1ps

module icy_parser (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic [7:0]        in_byte,
    output logic              in_ready,
    input  logic              cfg_valid,
    input  logic [15:0]       cfg_data,
    output logic              cfg_ready,
    input  logic              can_load,
    output logic              load,
    output icy_pkg::bundle_t  bundle
);

    logic [15:0]            interval_reg;
    icy_pkg::frame_phase_t  phase_reg, phase_next;
    logic [15:0]            audio_count_reg, audio_count_next;
    logic [11:0]            meta_rem_reg, meta_rem_next;
    logic [3:0]             prefix_pos_reg, prefix_pos_next;
    icy_pkg::search_phase_t search_reg, search_next;
    logic                   quote_reg, quote_next;
    logic                   nonempty_reg, nonempty_next;

    logic [15:0]            count_sum;
    logic [11:0]            rem_dec;
    logic [1:0]             k;
    icy_pkg::result_t [2:0] res;
    logic                   accept;

    assign cfg_ready = 1'b1;
    assign in_ready  = can_load;
    assign accept    = in_valid && can_load;
    assign load      = accept && (k != 2'd0);
    assign bundle    = '{res: res, count: k};

    always_comb
    begin
        phase_next       = phase_reg;
        audio_count_next = audio_count_reg;
        meta_rem_next    = meta_rem_reg;
        prefix_pos_next  = prefix_pos_reg;
        search_next      = search_reg;
        quote_next       = quote_reg;
        nonempty_next    = nonempty_reg;
        count_sum        = audio_count_reg + 16'd1;
        rem_dec          = (meta_rem_reg != 12'd0) ? meta_rem_reg - 12'd1 : meta_rem_reg;
        k                = 2'd0;
        res              = '0;
        if (interval_reg == 16'd0)
        begin
            res[k] = '{kind: icy_pkg::KIND_AUDIO, data: in_byte};
            k      = k + 2'd1;
        end
        else
        begin
            case (phase_reg)
                icy_pkg::PH_AUDIO:
                begin
                    res[k] = '{kind: icy_pkg::KIND_AUDIO, data: in_byte};
                    k      = k + 2'd1;
                    audio_count_next = count_sum;
                    if (count_sum >= interval_reg)
                    begin
                        audio_count_next = 16'd0;
                        phase_next       = icy_pkg::PH_LENGTH;
                    end
                end
                icy_pkg::PH_LENGTH:
                begin
                    meta_rem_next    = {in_byte, 4'b0000};
                    prefix_pos_next  = 4'd0;
                    search_next      = icy_pkg::SP_SEARCH;
                    quote_next       = 1'b0;
                    nonempty_next    = 1'b0;
                    audio_count_next = 16'd0;
                    phase_next = (in_byte != 8'd0) ? icy_pkg::PH_META : icy_pkg::PH_AUDIO;
                end
                icy_pkg::PH_META:
                begin
                    case (search_reg)
                        icy_pkg::SP_SEARCH:
                        begin
                            if (in_byte == icy_pkg::CHAR_NUL)
                            begin
                                search_next = icy_pkg::SP_DONE;
                            end
                            else if (prefix_pos_reg < icy_pkg::PREFIX_LEN &&
                                     in_byte == icy_pkg::prefix_char(prefix_pos_reg))
                            begin
                                prefix_pos_next = prefix_pos_reg + 4'd1;
                                if (prefix_pos_next >= icy_pkg::PREFIX_LEN)
                                begin
                                    prefix_pos_next = 4'd0;
                                    search_next     = icy_pkg::SP_TITLE;
                                    quote_next      = 1'b0;
                                    nonempty_next   = 1'b0;
                                end
                            end
                            else
                            begin
                                prefix_pos_next = (in_byte == icy_pkg::CHAR_S) ? 4'd1 : 4'd0;
                            end
                        end
                        icy_pkg::SP_TITLE:
                        begin
                            if (in_byte == icy_pkg::CHAR_NUL)
                            begin
                                search_next = icy_pkg::SP_DONE;
                                quote_next  = 1'b0;
                                res[k] = '{kind: icy_pkg::KIND_DISCARD, data: 8'd0};
                                k      = k + 2'd1;
                            end
                            else if (in_byte == icy_pkg::CHAR_QUOTE)
                            begin
                                if (quote_reg)
                                begin
                                    res[k] = '{kind: icy_pkg::KIND_TITLE,
                                               data: icy_pkg::CHAR_QUOTE};
                                    k      = k + 2'd1;
                                    nonempty_next = 1'b1;
                                end
                                quote_next = 1'b1;
                            end
                            else if (in_byte == icy_pkg::CHAR_SEMI && quote_reg)
                            begin
                                quote_next  = 1'b0;
                                search_next = icy_pkg::SP_DONE;
                                res[k] = '{kind: nonempty_reg ? icy_pkg::KIND_COMPLETE
                                                              : icy_pkg::KIND_DISCARD,
                                           data: 8'd0};
                                k      = k + 2'd1;
                            end
                            else
                            begin
                                if (quote_reg)
                                begin
                                    res[k] = '{kind: icy_pkg::KIND_TITLE,
                                               data: icy_pkg::CHAR_QUOTE};
                                    k      = k + 2'd1;
                                    quote_next = 1'b0;
                                end
                                nonempty_next = 1'b1;
                                res[k] = '{kind: icy_pkg::KIND_TITLE, data: in_byte};
                                k      = k + 2'd1;
                            end
                        end
                        default:
                        begin
                        end
                    endcase
                    meta_rem_next = rem_dec;
                    if (rem_dec == 12'd0)
                    begin
                        // block over: a title still open is dropped
                        if (search_next == icy_pkg::SP_TITLE)
                        begin
                            res[k] = '{kind: icy_pkg::KIND_DISCARD, data: 8'd0};
                            k      = k + 2'd1;
                            search_next = icy_pkg::SP_DONE;
                        end
                        quote_next       = 1'b0;
                        phase_next       = icy_pkg::PH_AUDIO;
                        audio_count_next = 16'd0;
                    end
                end
                default:
                begin
                    phase_next = icy_pkg::PH_AUDIO;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            interval_reg    <= 16'd0;
            phase_reg       <= icy_pkg::PH_AUDIO;
            audio_count_reg <= 16'd0;
            meta_rem_reg    <= 12'd0;
            prefix_pos_reg  <= 4'd0;
            search_reg      <= icy_pkg::SP_SEARCH;
            quote_reg       <= 1'b0;
            nonempty_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                interval_reg <= cfg_data;
            end
            if (accept)
            begin
                phase_reg       <= phase_next;
                audio_count_reg <= audio_count_next;
                meta_rem_reg    <= meta_rem_next;
                prefix_pos_reg  <= prefix_pos_next;
                search_reg      <= search_next;
                quote_reg       <= quote_next;
                nonempty_reg    <= nonempty_next;
            end
        end
    end

endmodule

[design/icy_out_buf.sv]
// result register that hands out one to three results per input byte
`timescale 1ns / 1ps

module icy_out_buf (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  icy_pkg::bundle_t bundle,
    output logic             can_load,
    output logic             out_valid,
    input  logic             out_ready,
    output logic [1:0]       out_kind,
    output logic [7:0]       out_byte,
    output logic             last_of_run
);

    icy_pkg::result_t [2:0] res_reg;
    logic [1:0]             cnt_reg;
    logic [1:0]             pos_reg;
    logic                   pop;
    logic                   is_last;

    assign out_valid   = pos_reg < cnt_reg;
    assign is_last     = (pos_reg + 2'd1) == cnt_reg;
    assign pop         = out_valid && out_ready;
    assign can_load    = !out_valid || (pop && is_last);
    assign out_kind    = res_reg[pos_reg].kind;
    assign out_byte    = res_reg[pos_reg].data;
    assign last_of_run = is_last;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= bundle.res;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            pos_reg <= 2'd0;
        end
        else if (load)
        begin
            cnt_reg <= bundle.count;
            pos_reg <= 2'd0;
        end
        else if (pop)
        begin
            if (is_last)
            begin
                cnt_reg <= 2'd0;
                pos_reg <= 2'd0;
            end
            else
            begin
                pos_reg <= pos_reg + 2'd1;
            end
        end
    end

endmodule

[design/icy_checker.sv]
// port-level checks for the icy metadata demux and their bind
`timescale 1ns / 1ps

module icy_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       out_valid,
    input logic       out_ready,
    input logic [1:0] out_kind,
    input logic [7:0] out_byte,
    input logic       last_of_run
);

    // a stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_kind) && $stable(out_byte)
                                    && $stable(last_of_run))
    else $error("stalled result changed");

    // title events carry no byte
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_kind == icy_pkg::KIND_COMPLETE ||
                      out_kind == icy_pkg::KIND_DISCARD) |-> out_byte == 8'd0)
    else $error("title event with nonzero byte");

    // a title event always closes its byte's results
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (out_kind == icy_pkg::KIND_COMPLETE ||
                      out_kind == icy_pkg::KIND_DISCARD) |-> last_of_run)
    else $error("title event not last of run");

    // an audio byte is always the only result of its byte
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_kind == icy_pkg::KIND_AUDIO |-> last_of_run)
    else $error("audio result not last of run");

endmodule

bind icy_metadata_demux icy_checker u_icy_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .out_valid   (out_stream.valid),
    .out_ready   (out_stream.ready),
    .out_kind    (out_stream.out_kind),
    .out_byte    (out_stream.out_byte),
    .last_of_run (out_stream.last_of_run)
);
